/* sv/assert_macros.svh */
// Assertion macros used by the checker file of the timer wheel.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is held.
`define ASSERT_CLKD(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Clocked assertion, live during reset too.
`define ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

/* sv/itw_pkg.sv */
// Types and constants of the idle-timeout timer wheel.
// Used by all modules of the block; no dependencies.
package itw_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int MAX_BUCKETS = 16;
  localparam int ID_W        = 5;
  localparam int CNT_W       = 5;
  localparam int BKT_W       = 4;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 3;
  localparam int MQ_DEPTH    = 2;
  localparam int MQ_PTR_W    = $clog2(MQ_DEPTH);
  localparam int MQ_CNT_W    = $clog2(MQ_DEPTH + 1);
  localparam logic [CNT_W-1:0] BUCKET_COUNT_RST = CNT_W'(8);
  localparam logic CFG_IDX_BUCKET_COUNT = 1'b0;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_RENEW  = 2'd2,
    OP_TICK   = 2'd3
  } op_kind_e;

  typedef struct packed {
    op_kind_e        kind;
    logic [ID_W-1:0] entry_id;
    logic            erase_on_expiry;
  } item_t;

  typedef struct packed {
    logic [ID_W-1:0] expired_id;
    logic            last;
  } result_t;

  typedef logic [MAX_ENTRIES-1:0] mask_t;

endpackage

/* sv/idle_timeout_timer_wheel.sv */
// Idle-timeout timer wheel: front table, mask queue, back drain, APB config.
// Accepts one item per cycle while the two-entry mask queue has room.
// Add, remove and renew take effect at the accepting edge; a tick's due mask goes
// through the mask queue and the back's work register, then one beat per cycle while popped.
// Reset clears valid flags at once, pointer to 0, bucket_count to 8.
module idle_timeout_timer_wheel import itw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  item_t             item_i,
  output logic              empty,
  input  logic              pop,
  output result_t           result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [CNT_W-1:0] bucket_count_q;
  logic             accept, mq_push, mq_full, mq_nonempty, mq_pop;
  mask_t            mq_in, mq_out;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_IDX_BUCKET_COUNT) ? DATA_W'(bucket_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= BUCKET_COUNT_RST;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == CFG_IDX_BUCKET_COUNT) begin
      bucket_count_q <= pwdata[CNT_W-1:0];
    end
  end

  assign full   = mq_full;
  assign accept = push && !mq_full;

  itw_front u_front (
    .clk_i,
    .rst_ni,
    .accept_i       (accept),
    .item_i,
    .bucket_count_i (bucket_count_q),
    .mask_push_o    (mq_push),
    .mask_o         (mq_in)
  );

  itw_mask_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i     (mq_push),
    .data_i     (mq_in),
    .full_o     (mq_full),
    .pop_i      (mq_pop),
    .nonempty_o (mq_nonempty),
    .data_o     (mq_out)
  );

  itw_back u_back (
    .clk_i,
    .rst_ni,
    .mask_valid_i (mq_nonempty),
    .mask_i       (mq_out),
    .mask_pop_o   (mq_pop),
    .empty,
    .pop,
    .result_o
  );

endmodule

/* sv/itw_front.sv */
// Front of the timer wheel: entry table, bucket pointer and op decode.
// A tick leaves a mask of due entries for the back. Depends on itw_pkg.
module itw_front import itw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  item_t            item_i,
  input  logic [CNT_W-1:0] bucket_count_i,
  output logic             mask_push_o,
  output mask_t            mask_o
);

  logic [BKT_W-1:0] cur_q, cur_d;
  logic [MAX_ENTRIES-1:0] valid_q, valid_d;
  logic [BKT_W-1:0] bucket_q [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] erase_q;

  logic [CNT_W-1:0] n;
  logic [BKT_W-1:0] ptr_eff, newest, p_next;
  logic [CNT_W-1:0] p_inc;
  logic             on;
  mask_t            due;

  always_comb begin
    n       = (bucket_count_i > CNT_W'(MAX_BUCKETS)) ? CNT_W'(MAX_BUCKETS) : bucket_count_i;
    on      = (n != '0);
    ptr_eff = (CNT_W'(cur_q) >= n) ? '0 : cur_q;
    newest  = (ptr_eff == '0) ? BKT_W'(n - CNT_W'(1)) : ptr_eff - BKT_W'(1);
    p_inc   = CNT_W'(ptr_eff) + CNT_W'(1);
    p_next  = (p_inc >= n) ? '0 : p_inc[BKT_W-1:0];
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      due[i] = valid_q[i] && (bucket_q[i] == p_next);
    end
  end

  always_comb begin
    cur_d       = cur_q;
    valid_d     = valid_q;
    mask_push_o = 1'b0;
    mask_o      = due;
    if (accept_i) begin
      unique case (item_i.kind)
        OP_ADD: begin
          if (on) valid_d[item_i.entry_id] = 1'b1;
        end
        OP_REMOVE: valid_d[item_i.entry_id] = 1'b0;
        OP_RENEW: ;
        OP_TICK: begin
          if (on) begin
            cur_d       = p_next;
            valid_d     = valid_q & ~(due & erase_q);
            mask_push_o = (due != '0);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= '0;
      valid_q <= '0;
    end else begin
      cur_q   <= cur_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && on) begin
      if (item_i.kind == OP_ADD) begin
        bucket_q[item_i.entry_id] <= newest;
        erase_q[item_i.entry_id]  <= item_i.erase_on_expiry;
      end else if (item_i.kind == OP_RENEW && valid_q[item_i.entry_id]) begin
        bucket_q[item_i.entry_id] <= newest;
      end
    end
  end

endmodule

/* sv/itw_mask_queue.sv */
// Short queue of due-entry masks between front and back.
// Depends on itw_pkg.
module itw_mask_queue import itw_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  mask_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  nonempty_o,
  output mask_t data_o
);

  mask_t                mem_q [MQ_DEPTH];
  logic [MQ_PTR_W-1:0]  wr_q, rd_q;
  logic [MQ_CNT_W-1:0]  cnt_q;
  logic                 do_push, do_pop;

  assign full_o     = (cnt_q == MQ_CNT_W'(MQ_DEPTH));
  assign nonempty_o = (cnt_q != '0);
  assign data_o     = mem_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && nonempty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == MQ_PTR_W'(MQ_DEPTH - 1)) ? '0 : wr_q + MQ_PTR_W'(1);
      if (do_pop) rd_q <= (rd_q == MQ_PTR_W'(MQ_DEPTH - 1)) ? '0 : rd_q + MQ_PTR_W'(1);
      cnt_q <= cnt_q + MQ_CNT_W'(do_push) - MQ_CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

/* sv/itw_back.sv */
// Back of the timer wheel: drains due masks, one timeout beat per cycle
// unless pop stalls, lowest id first, into the result register. Depends on itw_pkg.
module itw_back import itw_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    mask_valid_i,
  input  mask_t   mask_i,
  output logic    mask_pop_o,
  output logic    empty,
  input  logic    pop,
  output result_t result_o
);

  mask_t           wk_q, wk_d, wk_rest;
  logic            out_valid_q, out_valid_d;
  result_t         out_q, out_d;
  logic            out_free, emit, single;
  logic [ID_W-1:0] low_id;

  always_comb begin
    low_id = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (wk_q[i]) low_id = ID_W'(i);
    end
  end

  always_comb begin
    wk_rest     = wk_q & (wk_q - mask_t'(1));
    single      = (wk_rest == '0);
    out_free    = !out_valid_q || pop;
    emit        = out_free && (wk_q != '0);
    wk_d        = emit ? wk_rest : wk_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      out_d.expired_id = low_id;
      out_d.last       = single;
      out_valid_d      = 1'b1;
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
    mask_pop_o = mask_valid_i && ((wk_q == '0) || (emit && single));
    if (mask_pop_o) wk_d = mask_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wk_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wk_q        <= wk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign empty    = !out_valid_q;
  assign result_o = out_q;

endmodule

/* sv/itw_checker.sv */
// Port-level checker for the timer wheel, bound to the top level.
// Depends on itw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module itw_checker import itw_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    empty,
  input logic    pop,
  input result_t result_o
);

  `ASSERT_CLK(a_empty_after_rst, clk_i, !rst_ni |=> empty)
  `ASSERT_CLKD(a_hold_stalled, clk_i, rst_ni,
    !empty && !pop |=> !empty && $stable(result_o))
  `ASSERT_CLKD(a_tick_continues, clk_i, rst_ni,
    !empty && pop && !result_o.last |=> !empty)
  `ASSERT_CLKD(a_ids_ascend, clk_i, rst_ni,
    !empty && pop && !result_o.last |=> result_o.expired_id > $past(result_o.expired_id))

endmodule

bind idle_timeout_timer_wheel itw_checker u_itw_checker (.*);

/* dv/testbench.sv */
`timescale 1ns / 100ps
// Self-checking bench for the idle-timeout timer wheel: add, remove, renew and tick beats
// are checked against an in-bench wheel model; bucket_count is set over APB between phases.
// Depends on itw_pkg and idle_timeout_timer_wheel.
module testbench;
  import itw_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 48;
  localparam logic [ADDR_W-1:0] BUCKET_COUNT_ADDR = ADDR_W'(4 * int'(CFG_IDX_BUCKET_COUNT));

  logic              clk_i   = 1'b0;
  logic              rst_ni  = 1'b0;
  logic              push    = 1'b0;
  logic              full;
  item_t             item_i  = '0;
  logic              empty;
  logic              pop     = 1'b0;
  result_t           result_o;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  logic [CNT_W-1:0]       bucket_count_q = BUCKET_COUNT_RST;
  logic [BKT_W-1:0]       wheel_ptr      = '0;
  logic [MAX_ENTRIES-1:0] entry_live     = '0;
  logic [BKT_W-1:0]       entry_slot [MAX_ENTRIES];
  logic                   entry_drop [MAX_ENTRIES];
  result_t                due_q [$];

  int          mismatches = 0;
  int unsigned cycles     = 0;
  bit          src_idles  = 1'b0;
  bit          sink_idles = 1'b0;
  int          sink_hold  = 0;

  idle_timeout_timer_wheel dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .item_i   (item_i),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL idle_timeout_timer_wheel");
      $finish;
    end
  end

  function automatic int live_buckets();
    return (bucket_count_q > CNT_W'(MAX_BUCKETS)) ? MAX_BUCKETS : int'(bucket_count_q);
  endfunction

  function automatic int ptr_seen(int n);
    return (int'(wheel_ptr) >= n) ? 0 : int'(wheel_ptr);
  endfunction

  function automatic logic [BKT_W-1:0] newest_slot(int n);
    int p;
    p = ptr_seen(n);
    return BKT_W'((p == 0) ? n - 1 : p - 1);
  endfunction

  function automatic void wheel_apply(item_t it);
    int      n;
    int      p;
    int      idx;
    result_t beat;
    bit      have;
    n    = live_buckets();
    have = 1'b0;
    beat = '0;
    if (it.kind == OP_TICK) begin
      if (n != 0) begin
        p = ptr_seen(n) + 1;
        if (p >= n) p = 0;
        wheel_ptr = BKT_W'(p);
        for (idx = 0; idx < MAX_ENTRIES; idx++) begin
          if (entry_live[idx] && int'(entry_slot[idx]) == p) begin
            if (have) due_q.push_back(beat);
            beat.expired_id = ID_W'(idx);
            beat.last       = 1'b0;
            have            = 1'b1;
            if (entry_drop[idx]) entry_live[idx] = 1'b0;
          end
        end
        if (have) begin
          beat.last = 1'b1;
          due_q.push_back(beat);
        end
      end
    end else if (int'(it.entry_id) < MAX_ENTRIES) begin
      idx = int'(it.entry_id);
      case (it.kind)
        OP_ADD: begin
          if (n != 0) begin
            entry_live[idx] = 1'b1;
            entry_slot[idx] = newest_slot(n);
            entry_drop[idx] = it.erase_on_expiry;
          end
        end
        OP_REMOVE: begin
          entry_live[idx] = 1'b0;
        end
        default: begin
          // renew: an entry already in the newest bucket keeps it anyway
          if (n != 0 && entry_live[idx]) entry_slot[idx] = newest_slot(n);
        end
      endcase
    end
  endfunction

  function automatic void check_expiry(result_t got);
    result_t want;
    if (due_q.size() == 0) begin
      $error("expired_id: unexpected beat, got %0d", got.expired_id);
      mismatches++;
    end else begin
      want = due_q.pop_front();
      if (got.expired_id !== want.expired_id) begin
        $error("expired_id: expected %0d, got %0d", want.expired_id, got.expired_id);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        mismatches++;
      end
    end
  endfunction

  task automatic send_beat(op_kind_e kind, int id, bit erase);
    item_t it;
    int    gap;
    it.kind            = kind;
    it.entry_id        = ID_W'(id);
    it.erase_on_expiry = erase;
    gap = src_idles ? $urandom_range(0, 15) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push   <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (full);
    wheel_apply(it);
  endtask

  task automatic hold_sender(int extra);
    @(negedge clk_i);
    push <= 1'b0;
    while (due_q.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic check_bucket_count();
    @(negedge clk_i);
    psel   <= 1'b1;
    pwrite <= 1'b0;
    paddr  <= BUCKET_COUNT_ADDR;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[CNT_W-1:0] !== bucket_count_q) begin
      $error("bucket_count: expected %0d, got %0d", bucket_count_q, prdata[CNT_W-1:0]);
      mismatches++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_bucket_count(logic [CNT_W-1:0] val);
    hold_sender(SETTLE_CYCLES);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= BUCKET_COUNT_ADDR;
    pwdata  <= DATA_W'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    bucket_count_q = val;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    check_bucket_count();
  endtask

  initial begin : beat_sink
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = sink_idles ? $urandom_range(0, 15) : 0;
      @(negedge clk_i);
      if (sink_hold > 0) begin
        pop <= 1'b0;
        repeat (sink_hold) @(negedge clk_i);
        sink_hold = 0;
      end else if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      check_expiry(result_o);
    end
  end

  task automatic test_reset_value();
    check_bucket_count();
  endtask

  task automatic test_table_ops();
    src_idles  = 1'b0;
    sink_idles = 1'b0;
    send_beat(OP_ADD, 0, 1'b1);
    send_beat(OP_ADD, MAX_ENTRIES - 1, 1'b0);
    send_beat(OP_ADD, 10, 1'b1);
    send_beat(OP_REMOVE, 5, 1'b0);
    send_beat(OP_RENEW, 6, 1'b0);
    send_beat(OP_TICK, 0, 1'b0);
    send_beat(OP_ADD, 10, 1'b0);
    send_beat(OP_RENEW, MAX_ENTRIES - 1, 1'b1);
    send_beat(OP_RENEW, 10, 1'b0);
    repeat (7) send_beat(OP_TICK, 21, 1'b1);
  endtask

  task automatic test_wheel_disabled();
    write_bucket_count('0);
    send_beat(OP_ADD, 3, 1'b1);
    send_beat(OP_RENEW, MAX_ENTRIES - 1, 1'b0);
    send_beat(OP_TICK, 0, 1'b0);
    send_beat(OP_REMOVE, MAX_ENTRIES - 1, 1'b0);
  endtask

  task automatic test_pointer_beyond_count();
    write_bucket_count(CNT_W'(MAX_BUCKETS));
    send_beat(OP_ADD, 7, 1'b0);
    repeat (3) send_beat(OP_TICK, 0, 1'b0);
    write_bucket_count(CNT_W'(3));
    repeat (3) send_beat(OP_TICK, 0, 1'b0);
    send_beat(OP_RENEW, 7, 1'b0);
    repeat (2) send_beat(OP_TICK, 0, 1'b0);
  endtask

  task automatic test_backpressure();
    int k;
    write_bucket_count(CNT_W'(4));
    src_idles  = 1'b0;
    sink_idles = 1'b0;
    sink_hold  = 400;
    for (k = 0; k < 24; k++) begin
      if (k % 4 == 3) send_beat(OP_TICK, 0, 1'b0);
      else send_beat(OP_ADD, k, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_sender_pause();
    int k;
    src_idles  = 1'b1;
    sink_idles = 1'b1;
    for (k = 0; k < 8; k++) begin
      if (k % 2 == 1) send_beat(OP_TICK, 0, 1'b0);
      else send_beat(OP_ADD, $urandom_range(0, 31), 1'($urandom_range(0, 1)));
    end
    hold_sender(0);
    repeat (4) send_beat(OP_TICK, $urandom_range(0, 31), 1'b0);
  endtask

  task automatic test_random_mix();
    int       phase_counts [8] = '{1, 2, 0, 16, 31, 5, 17, 0};
    int       ph;
    int       r;
    op_kind_e kind;
    for (ph = 0; ph < 8; ph++) begin
      if (ph == 7) write_bucket_count(CNT_W'($urandom_range(1, 31)));
      else write_bucket_count(CNT_W'(phase_counts[ph]));
      src_idles  = 1'($urandom_range(0, 1));
      sink_idles = 1'($urandom_range(0, 1));
      repeat (44) begin
        r = $urandom_range(0, 99);
        if (r < 40) kind = OP_ADD;
        else if (r < 55) kind = OP_REMOVE;
        else if (r < 75) kind = OP_RENEW;
        else kind = OP_TICK;
        send_beat(kind, $urandom_range(0, 31), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin : run
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_value();
    test_table_ops();
    test_wheel_disabled();
    test_pointer_beyond_count();
    test_backpressure();
    test_sender_pause();
    test_random_mix();
    hold_sender(SETTLE_CYCLES);
    if (mismatches == 0) begin
      $display("PASS idle_timeout_timer_wheel");
    end else begin
      $display("FAIL idle_timeout_timer_wheel");
    end
    $finish;
  end

endmodule
